// ===== hdl/tal_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermistor average/linearize package
// Shared constants, band tables, result type and constant-divide helpers.
// ----------------------------------------------------------------------------
package tal_pkg;

   localparam int SAMPLE_BITS = 12;

   // Reset value of the report interval register.
   localparam logic [15:0] INTERVAL_RESET = 16'd10000;

   // Band codes.
   localparam logic [2:0] BAND_NONE  = 3'd0;
   localparam logic [2:0] BAND_ONE   = 3'd1;
   localparam logic [2:0] BAND_TWO   = 3'd2;
   localparam logic [2:0] BAND_THREE = 3'd3;
   localparam logic [2:0] BAND_FOUR  = 3'd4;

   // Upper and lower edges of bands one to three and the top of band four; band four runs down to zero.
   localparam logic [SAMPLE_BITS-1:0] BAND_ONE_TOP   = 12'd3700;
   localparam logic [SAMPLE_BITS-1:0] BAND_ONE_LOW   = 12'd2817;
   localparam logic [SAMPLE_BITS-1:0] BAND_TWO_TOP   = 12'd2816;
   localparam logic [SAMPLE_BITS-1:0] BAND_TWO_LOW   = 12'd1663;
   localparam logic [SAMPLE_BITS-1:0] BAND_THREE_TOP = 12'd1662;
   localparam logic [SAMPLE_BITS-1:0] BAND_THREE_LOW = 12'd819;
   localparam logic [SAMPLE_BITS-1:0] BAND_FOUR_TOP  = 12'd818;

   // Millidegree value above which the code is given in hundredths.
   localparam logic [16:0] MILLI_LIMIT = 17'd10000;

   // floor(n / 25) = (n * RECIP_25) >> RECIP_25_SHIFT, exact for n below 2**20.
   localparam logic [20:0] RECIP_25       = 21'd1342178;
   localparam int          RECIP_25_SHIFT = 25;

   // floor(n / 10) = (n * RECIP_10) >> RECIP_10_SHIFT, exact for n below 2**17.
   localparam logic [17:0] RECIP_10       = 18'd209716;
   localparam int          RECIP_10_SHIFT = 21;

   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // One report as it leaves the block.
   typedef struct packed {
      logic [5:0]  digit_ones;
      logic [5:0]  digit_tens;
      logic [5:0]  digit_hundreds;
      logic [5:0]  digit_thousands;
      logic [2:0]  band;
      logic [13:0] temp_code;
   } tal_result_type;

   // Segment that holds an average; above the top of band one is no band.
   function automatic logic [2:0] band_of(input logic [SAMPLE_BITS-1:0] avg);
      logic [2:0] b;
      if (avg > BAND_ONE_TOP) begin
         b = BAND_NONE;
      end else if (avg >= BAND_ONE_LOW) begin
         b = BAND_ONE;
      end else if (avg >= BAND_TWO_LOW) begin
         b = BAND_TWO;
      end else if (avg >= BAND_THREE_LOW) begin
         b = BAND_THREE;
      end else begin
         b = BAND_FOUR;
      end
      return b;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] band_top(input logic [2:0] b);
      logic [SAMPLE_BITS-1:0] t;
      case (b)
         BAND_ONE:   t = BAND_ONE_TOP;
         BAND_TWO:   t = BAND_TWO_TOP;
         BAND_THREE: t = BAND_THREE_TOP;
         BAND_FOUR:  t = BAND_FOUR_TOP;
         default:    t = '0;
      endcase
      return t;
   endfunction

   // Slope per converter count in units of 1e-5 degree.
   function automatic logic [11:0] band_coef(input logic [2:0] b);
      logic [11:0] c;
      case (b)
         BAND_ONE:   c = 12'd2830;
         BAND_TWO:   c = 12'd2168;
         BAND_THREE: c = 12'd2960;
         BAND_FOUR:  c = 12'd3056;
         default:    c = 12'd0;
      endcase
      return c;
   endfunction

   // Band offset already scaled to millidegrees.
   function automatic logic [16:0] band_offset_milli(input logic [2:0] b);
      logic [16:0] o;
      case (b)
         BAND_TWO:   o = 17'd25000;
         BAND_THREE: o = 17'd50000;
         BAND_FOUR:  o = 17'd75000;
         default:    o = 17'd0;
      endcase
      return o;
   endfunction

   // Exact floor(n / 10) for any 17-bit n.
   function automatic logic [13:0] div10(input logic [16:0] n);
      logic [34:0] p;
      p = {18'd0, n} * {17'd0, RECIP_10};
      return p[RECIP_10_SHIFT+13:RECIP_10_SHIFT];
   endfunction

endpackage

// ===== hdl/tal_linearize.sv =====
// ----------------------------------------------------------------------------
// Thermistor linearizer pipeline
// Takes a reported average through band lookup, slope multiply, scaling and
// decimal digit extraction, one stage per register, one report per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tal_linearize (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [tal_pkg::SAMPLE_BITS-1:0]     in_avg,
   output logic                                out_valid,
   input  logic                                out_ready,
   output tal_pkg::tal_result_type             out_result
);
   import tal_pkg::*;

   localparam int STAGES = 7;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] free;
   logic [STAGES-1:0] move;

   // Stage payloads.
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [21:0]            prod_ff;
   logic [2:0]             band1_ff, band2_ff, band3_ff, band4_ff, band5_ff, band6_ff;
   logic [16:0]            milli_ff;
   logic [13:0]            code3_ff, code4_ff, code5_ff, code6_ff;
   logic [9:0]             q1_ff;
   logic [6:0]             q2_ff;
   logic [3:0]             d0_4_ff, d0_5_ff, d1_5_ff;

   // Stage work.
   logic [2:0]             band_calc;
   logic [10:0]            diff;
   logic [SAMPLE_BITS-1:0] diff_full;
   logic [22:0]            prod_full;
   logic [40:0]            scaled;
   logic [14:0]            q100;
   logic [13:0]            code_calc;
   logic [13:0]            q1_full, q2_full, q3_full;
   logic [13:0]            rem0;
   logic [9:0]             rem1;
   logic [6:0]             rem2;
   logic [3:0]             d2, d3;

   // Each stage moves on when the next one is empty or moving too.
   always_comb begin
      move[STAGES-1] = valid_ff[STAGES-1] && out_ready;
      free[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         move[i] = valid_ff[i] && free[i+1];
         free[i] = !valid_ff[i] || free[i+1];
      end
      valid_in[0] = (valid_ff[0] && !move[0]) || in_valid;
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = (valid_ff[i] && !move[i]) || move[i-1];
      end
   end

   assign in_ready = free[0];

   // Band lookup and slope multiply; band none has zero slope and offset.
   always_comb begin
      band_calc = band_of(avg_ff);
      diff_full = band_top(band_calc) - avg_ff;
      diff      = diff_full[10:0];
      prod_full = {12'd0, diff} * {11'd0, band_coef(band_calc)};
   end

   // Divide by one hundred as a shift by two and a reciprocal for 25.
   always_comb begin
      scaled = {21'd0, prod_ff[21:2]} * {20'd0, RECIP_25};
      q100   = scaled[RECIP_25_SHIFT+14:RECIP_25_SHIFT];
   end

   // Large values are reported in hundredths.
   assign code_calc = (milli_ff > MILLI_LIMIT) ? div10(milli_ff) : milli_ff[13:0];

   // Decimal digits, one division by ten per stage.
   always_comb begin
      q1_full = div10({3'd0, code4_ff});
      rem0    = code4_ff - ({q1_full[10:0], 3'd0} + {q1_full[12:0], 1'b0});
      q2_full = div10({7'd0, q1_ff});
      rem1    = q1_ff - ({q2_full[6:0], 3'd0} + {q2_full[8:0], 1'b0});
      q3_full = div10({10'd0, q2_ff});
      rem2    = q2_ff - ({q3_full[3:0], 3'd0} + {q3_full[5:0], 1'b0});
      d2      = rem2[3:0];
      d3      = q3_full[3:0];
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage payload registers load when the previous stage moves in.
   always_ff @(posedge clock) begin
      if (in_valid && free[0]) begin
         avg_ff <= in_avg;
      end
      if (move[0]) begin
         prod_ff  <= prod_full[21:0];
         band1_ff <= band_calc;
      end
      if (move[1]) begin
         milli_ff <= {2'd0, q100} + band_offset_milli(band1_ff);
         band2_ff <= band1_ff;
      end
      if (move[2]) begin
         code3_ff <= code_calc;
         band3_ff <= band2_ff;
      end
      if (move[3]) begin
         code4_ff <= code3_ff;
         band4_ff <= band3_ff;
      end
      if (move[4]) begin
         q1_ff    <= q1_full[9:0];
         d0_4_ff  <= rem0[3:0];
         code5_ff <= code4_ff;
         band5_ff <= band4_ff;
      end
      if (move[5]) begin
         q2_ff    <= q2_full[6:0];
         d1_5_ff  <= rem1[3:0];
         d0_5_ff  <= d0_4_ff;
         code6_ff <= code5_ff;
         band6_ff <= band5_ff;
      end
   end

   // The last stage finishes the two upper digits on the way out.
   always_comb begin
      out_result.temp_code       = code6_ff;
      out_result.band            = band6_ff;
      out_result.digit_ones      = ASCII_ZERO + {2'd0, d0_5_ff};
      out_result.digit_tens      = ASCII_ZERO + {2'd0, d1_5_ff};
      out_result.digit_hundreds  = ASCII_ZERO + {2'd0, d2};
      out_result.digit_thousands = ASCII_ZERO + {2'd0, d3};
   end

   assign out_valid = valid_ff[STAGES-1];

endmodule

// ===== hdl/thermistor_average_linearize_report.sv =====
// ----------------------------------------------------------------------------
// Thermistor average, linearize and report
// Running average of converter samples with a periodic temperature report.
// ----------------------------------------------------------------------------
// One sample is taken per cycle while req_tready is high; the running average
// and the sample counter are updated in the cycle the sample transfer completes.
// Every report_interval+1 samples the block issues one report carrying the
// temperature code, the band used and four ASCII digits. The sample that
// completes the interval enters the linearizer's first stage and passes through
// its registered stages to rsp_tvalid; the pipeline passes one report per cycle
// while rsp_tready is high and only stalls samples that would start a report
// while waiting results have backed it up to its first stage.
module thermistor_average_linearize_report (
   input  logic        clock,
   input  logic        reset,
   // Sample input: [11:0] sample, [15:12] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Report output: [13:0] temp_code, [16:14] band, [22:17] digit_thousands,
   // [28:23] digit_hundreds, [34:29] digit_tens, [40:35] digit_ones, [47:41] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tal_pkg::*;

   logic [15:0]            interval_ff;
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [SAMPLE_BITS-1:0] avg_in;
   logic [15:0]            count_ff;
   logic                   first_ff;
   logic [SAMPLE_BITS:0]   avg_sum;
   logic                   report_due;
   logic                   accept;
   logic                   lin_ready;
   tal_result_type         lin_result;

   // A report falls due once the counter has reached the limit.
   assign report_due = (count_ff >= interval_ff);
   assign req_tready = !report_due || lin_ready;
   assign accept     = req_tvalid && req_tready;

   // Next running average; the first sample loads it directly.
   always_comb begin
      avg_sum = {1'b0, avg_ff} + {1'b0, req_tdata[SAMPLE_BITS-1:0]};
      avg_in  = first_ff ? req_tdata[SAMPLE_BITS-1:0] : avg_sum[SAMPLE_BITS:1];
   end

   // Interval register, running average and sample counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         avg_ff      <= '0;
         count_ff    <= '0;
         first_ff    <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         if (accept) begin
            avg_ff   <= avg_in;
            first_ff <= 1'b0;
            count_ff <= report_due ? 16'd0 : count_ff + 16'd1;
         end
      end
   end

   tal_linearize u_linearize (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept && report_due),
      .in_ready   (lin_ready),
      .in_avg     (avg_in),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (lin_result)
   );

   assign rsp_tdata = {7'd0, lin_result};

   // A report with no band has a zero code and ASCII zero ones and thousands digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (lin_result.band == BAND_NONE) |->
         (lin_result.temp_code == 14'd0) && (lin_result.digit_ones == ASCII_ZERO) &&
         (lin_result.digit_thousands == ASCII_ZERO))
      else $error("out-of-range report is not zero");

   // The code never needs more than four digits and the band is at most band four.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lin_result.temp_code <= 14'd9999) && (lin_result.band <= BAND_FOUR))
      else $error("report code or band out of range");

   // Every digit is an ASCII decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (lin_result.digit_ones >= ASCII_ZERO) && (lin_result.digit_ones <= 6'd57) &&
         (lin_result.digit_tens >= ASCII_ZERO) && (lin_result.digit_tens <= 6'd57) &&
         (lin_result.digit_hundreds >= ASCII_ZERO) && (lin_result.digit_hundreds <= 6'd57) &&
         (lin_result.digit_thousands >= ASCII_ZERO) &&
         (lin_result.digit_thousands <= 6'd57))
      else $error("report digit is not a decimal digit");

   // The first-sample flag clears only on a sample transfer.
   assert property (@(posedge clock) disable iff (reset)
      $fell(first_ff) |-> $past(accept))
      else $error("first-sample flag cleared without a transfer");

endmodule
